// File: rtl/core/trfd_pkg.sv
// ----------------------------------------------------------------------------
// trfd_pkg
// Shared constants, codes and controller/datapath interface types for the
// trace FIFO drain tracker.
// ----------------------------------------------------------------------------
package trfd_pkg;

    localparam int MAX_PARAGRAPHS  = 64;
    localparam int PARAGRAPH_BYTES = 1024;
    localparam int PAR_SHIFT       = $clog2(PARAGRAPH_BYTES);

    localparam int WORD_W  = 32;
    localparam int QUOT_W  = WORD_W - PAR_SHIFT;
    localparam int IDX_W   = 6;
    localparam int PCNT_W  = 7;
    localparam int LOST_W  = 16;
    localparam int KIND_W  = 2;
    localparam int DCNT_W  = $clog2(QUOT_W + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FIFO_BOTTOM     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARAGRAPH_COUNT = 1'd1;

    localparam logic [PCNT_W-1:0] PCOUNT_RESET = 7'd8;
    localparam logic [PCNT_W-1:0] PCOUNT_MAX   = PCNT_W'(MAX_PARAGRAPHS);
    localparam logic [LOST_W-1:0] LOST_SAT     = {LOST_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTHING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NORUN   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STARTED = 2'd3;

    typedef struct packed {
        logic              capture;
        logic              acc_ovr;
        logic              div_start;
        logic              div_sel_next;
        logic              set_next;
        logic              do_start;
        logic              do_eval;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
    } trfd_cmd_t;

    typedef struct packed {
        logic req_start;
        logic running;
        logic next_ge_n;
        logic div_done;
        logic rem_zero;
    } trfd_status_t;

endpackage

// File: rtl/core/trfd_rem.sv
// ----------------------------------------------------------------------------
// trfd_rem
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// ----------------------------------------------------------------------------
module trfd_rem
    import trfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [QUOT_W-1:0] dividend,
    input  logic [PCNT_W-1:0] divisor,
    output logic              done,
    output logic [IDX_W-1:0]  rem
);

    logic [QUOT_W-1:0] shift_reg, shift_next;
    logic [PCNT_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0] count_reg, count_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PCNT_W:0]   trial;

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, shift_reg[QUOT_W-1]};
        if (start && !busy_reg)
        begin
            shift_next = dividend;
            rem_next   = '0;
            count_next = DCNT_W'(QUOT_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = PCNT_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[PCNT_W-1:0];
            end
            count_next = count_reg - 1'b1;
            if (count_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            rem_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[IDX_W-1:0];

endmodule

// File: rtl/core/trfd_dp.sv
// ----------------------------------------------------------------------------
// trfd_dp
// Datapath: configuration, tracker state, lap evaluation and the output
// word register.
// ----------------------------------------------------------------------------
module trfd_dp
    import trfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 req_type,
    input  logic [WORD_W-1:0]    write_pointer,
    input  logic [WORD_W-1:0]    overrun_count,
    input  trfd_cmd_t            cmd,
    output trfd_status_t         status,
    output logic [KIND_W-1:0]    result_kind,
    output logic [IDX_W-1:0]     paragraph_index,
    output logic [WORD_W-1:0]    buffer_offset,
    output logic [WORD_W-1:0]    sequence_res,
    output logic [LOST_W-1:0]    lost_paragraphs,
    output logic                 gap_flag,
    output logic [WORD_W-1:0]    total_overruns,
    output logic [WORD_W-1:0]    total_laps,
    output logic [WORD_W-1:0]    total_lost,
    output logic                 last
);

    logic [WORD_W-1:0] fifo_bottom_reg, fifo_bottom_next;
    logic [PCNT_W-1:0] pcount_reg, pcount_next;
    logic              req_reg, req_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [WORD_W-1:0] ovr_reg, ovr_next;
    logic              running_reg, running_next;
    logic [IDX_W-1:0]  next_par_reg, next_par_next;
    logic [WORD_W-1:0] last_ovr_reg, last_ovr_next;
    logic [WORD_W-1:0] seq_reg, seq_next;
    logic [LOST_W-1:0] pending_reg, pending_next;
    logic [WORD_W-1:0] ovr_total_reg, ovr_total_next;
    logic [WORD_W-1:0] lap_total_reg, lap_total_next;
    logic [WORD_W-1:0] lost_total_reg, lost_total_next;
    logic [IDX_W-1:0]  remain_reg, remain_next;

    logic [KIND_W-1:0] o_kind_reg, o_kind_next;
    logic [IDX_W-1:0]  o_idx_reg, o_idx_next;
    logic [WORD_W-1:0] o_off_reg, o_off_next;
    logic [WORD_W-1:0] o_seq_reg, o_seq_next;
    logic [LOST_W-1:0] o_lost_reg, o_lost_next;
    logic [WORD_W-1:0] o_tovr_reg, o_tovr_next;
    logic [WORD_W-1:0] o_tlap_reg, o_tlap_next;
    logic [WORD_W-1:0] o_tlost_reg, o_tlost_next;
    logic              o_last_reg, o_last_next;

    logic [PCNT_W-1:0] n_used;
    logic              div_done;
    logic [IDX_W-1:0]  div_rem;
    logic [QUOT_W-1:0] div_dividend;
    logic [IDX_W+1:0]  sum;
    logic [IDX_W+1:0]  avail_wide;
    logic [IDX_W-1:0]  avail;
    logic              lap;
    logic [PCNT_W-1:0] lap_lost;
    logic [LOST_W:0]   pend_sum;
    logic [WORD_W-1:0] diff;
    logic [IDX_W-1:0]  adv_wide;
    logic [PCNT_W-1:0] adv_sum;
    logic [WORD_W-1:0] next_offset;

    always_comb
    begin
        if (pcount_reg == '0)
        begin
            n_used = PCNT_W'(1);
        end
        else if (pcount_reg > PCOUNT_MAX)
        begin
            n_used = PCOUNT_MAX;
        end
        else
        begin
            n_used = pcount_reg;
        end
    end

    assign div_dividend = cmd.div_sel_next ? QUOT_W'(next_par_reg) : quot_reg;

    trfd_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (n_used),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb
    begin
        diff       = write_pointer - fifo_bottom_reg;
        sum        = (IDX_W+2)'(div_rem) + (IDX_W+2)'(n_used) - (IDX_W+2)'(next_par_reg);
        avail_wide = (sum >= (IDX_W+2)'(n_used)) ? sum - (IDX_W+2)'(n_used) : sum;
        avail      = avail_wide[IDX_W-1:0];
        lap        = (avail != '0) && ({1'b0, avail} >= n_used - 1'b1);
        lap_lost   = {1'b0, avail} + PCNT_W'(2) - n_used;
        pend_sum   = {1'b0, pending_reg} + (LOST_W+1)'(lap_lost);
        adv_sum    = {1'b0, next_par_reg} + 1'b1;
        adv_wide   = (adv_sum == n_used) ? '0 : adv_sum[IDX_W-1:0];
        next_offset = fifo_bottom_reg + (WORD_W'(next_par_reg) << PAR_SHIFT);
    end

    always_comb
    begin
        fifo_bottom_next = fifo_bottom_reg;
        pcount_next      = pcount_reg;
        req_next         = req_reg;
        quot_next        = quot_reg;
        ovr_next         = ovr_reg;
        running_next     = running_reg;
        next_par_next    = next_par_reg;
        last_ovr_next    = last_ovr_reg;
        seq_next         = seq_reg;
        pending_next     = pending_reg;
        ovr_total_next   = ovr_total_reg;
        lap_total_next   = lap_total_reg;
        lost_total_next  = lost_total_reg;
        remain_next      = remain_reg;
        o_kind_next      = o_kind_reg;
        o_idx_next       = o_idx_reg;
        o_off_next       = o_off_reg;
        o_seq_next       = o_seq_reg;
        o_lost_next      = o_lost_reg;
        o_tovr_next      = o_tovr_reg;
        o_tlap_next      = o_tlap_reg;
        o_tlost_next     = o_tlost_reg;
        o_last_next      = o_last_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FIFO_BOTTOM:     fifo_bottom_next = cfg_data;
                REG_PARAGRAPH_COUNT: pcount_next = cfg_data[PCNT_W-1:0];
                default:             fifo_bottom_next = fifo_bottom_reg;
            endcase
        end

        if (cmd.capture)
        begin
            req_next  = req_type;
            quot_next = diff[WORD_W-1:PAR_SHIFT];
            ovr_next  = overrun_count;
        end

        if (cmd.acc_ovr)
        begin
            ovr_total_next = ovr_total_reg + (ovr_reg - last_ovr_reg);
            last_ovr_next  = ovr_reg;
        end

        if (cmd.set_next)
        begin
            next_par_next = div_rem;
        end

        if (cmd.do_start)
        begin
            next_par_next   = div_rem;
            last_ovr_next   = ovr_reg;
            seq_next        = '0;
            pending_next    = '0;
            ovr_total_next  = '0;
            lap_total_next  = '0;
            lost_total_next = '0;
            running_next    = 1'b1;
            remain_next     = '0;
        end

        if (cmd.do_eval)
        begin
            if (lap)
            begin
                lap_total_next  = lap_total_reg + 1'b1;
                lost_total_next = lost_total_reg + WORD_W'(lap_lost);
                pending_next    = pend_sum[LOST_W] ? LOST_SAT : pend_sum[LOST_W-1:0];
                next_par_next   = div_rem;
                remain_next     = '0;
            end
            else
            begin
                remain_next = avail;
            end
        end

        if (cmd.out_load)
        begin
            o_kind_next  = cmd.out_kind;
            o_idx_next   = next_par_reg;
            o_off_next   = next_offset;
            o_seq_next   = seq_reg;
            o_lost_next  = pending_reg;
            o_tovr_next  = ovr_total_reg;
            o_tlap_next  = lap_total_reg;
            o_tlost_next = lost_total_reg;
            o_last_next  = 1'b1;
            case (cmd.out_kind)
                KIND_READ:
                begin
                    o_last_next   = (remain_reg == IDX_W'(1));
                    seq_next      = seq_reg + 1'b1;
                    pending_next  = '0;
                    next_par_next = adv_wide;
                    remain_next   = remain_reg - 1'b1;
                end
                KIND_NOTHING:
                begin
                    o_last_next = 1'b1;
                end
                KIND_NORUN:
                begin
                    o_idx_next   = '0;
                    o_off_next   = '0;
                    o_seq_next   = '0;
                    o_lost_next  = '0;
                    o_tovr_next  = '0;
                    o_tlap_next  = '0;
                    o_tlost_next = '0;
                end
                default:
                begin
                    o_seq_next   = '0;
                    o_lost_next  = '0;
                    o_tovr_next  = '0;
                    o_tlap_next  = '0;
                    o_tlost_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_bottom_reg <= '0;
            pcount_reg      <= PCOUNT_RESET;
            req_reg         <= 1'b0;
            quot_reg        <= '0;
            ovr_reg         <= '0;
            running_reg     <= 1'b0;
            next_par_reg    <= '0;
            last_ovr_reg    <= '0;
            seq_reg         <= '0;
            pending_reg     <= '0;
            ovr_total_reg   <= '0;
            lap_total_reg   <= '0;
            lost_total_reg  <= '0;
            remain_reg      <= '0;
            o_kind_reg      <= '0;
            o_idx_reg       <= '0;
            o_off_reg       <= '0;
            o_seq_reg       <= '0;
            o_lost_reg      <= '0;
            o_tovr_reg      <= '0;
            o_tlap_reg      <= '0;
            o_tlost_reg     <= '0;
            o_last_reg      <= 1'b0;
        end
        else
        begin
            fifo_bottom_reg <= fifo_bottom_next;
            pcount_reg      <= pcount_next;
            req_reg         <= req_next;
            quot_reg        <= quot_next;
            ovr_reg         <= ovr_next;
            running_reg     <= running_next;
            next_par_reg    <= next_par_next;
            last_ovr_reg    <= last_ovr_next;
            seq_reg         <= seq_next;
            pending_reg     <= pending_next;
            ovr_total_reg   <= ovr_total_next;
            lap_total_reg   <= lap_total_next;
            lost_total_reg  <= lost_total_next;
            remain_reg      <= remain_next;
            o_kind_reg      <= o_kind_next;
            o_idx_reg       <= o_idx_next;
            o_off_reg       <= o_off_next;
            o_seq_reg       <= o_seq_next;
            o_lost_reg      <= o_lost_next;
            o_tovr_reg      <= o_tovr_next;
            o_tlap_reg      <= o_tlap_next;
            o_tlost_reg     <= o_tlost_next;
            o_last_reg      <= o_last_next;
        end
    end

    assign status.req_start = !req_reg;
    assign status.running   = running_reg;
    assign status.next_ge_n = ({1'b0, next_par_reg} >= n_used);
    assign status.div_done  = div_done;
    assign status.rem_zero  = (remain_reg == '0);

    assign result_kind     = o_kind_reg;
    assign paragraph_index = o_idx_reg;
    assign buffer_offset   = o_off_reg;
    assign sequence_res    = o_seq_reg;
    assign lost_paragraphs = o_lost_reg;
    assign gap_flag        = (o_lost_reg != '0);
    assign total_overruns  = o_tovr_reg;
    assign total_laps      = o_tlap_reg;
    assign total_lost      = o_tlost_reg;
    assign last            = o_last_reg;

endmodule

// File: rtl/core/trfd_ctrl.sv
// ----------------------------------------------------------------------------
// trfd_ctrl
// Controller: sequences capture, remainder runs, evaluation and the
// emission of output words.
// ----------------------------------------------------------------------------
module trfd_ctrl
    import trfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  trfd_status_t status,
    output trfd_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIVN = 3'd2;
    localparam logic [2:0] S_DIVP = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_kind = KIND_READ;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                if (status.req_start)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVP;
                end
                else if (!status.running)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.acc_ovr   = 1'b1;
                    cmd.div_start = 1'b1;
                    if (status.next_ge_n)
                    begin
                        cmd.div_sel_next = 1'b1;
                        state_next       = S_DIVN;
                    end
                    else
                    begin
                        state_next = S_DIVP;
                    end
                end
            end
            S_DIVN:
            begin
                if (status.div_done)
                begin
                    cmd.set_next  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVP;
                end
            end
            S_DIVP:
            begin
                if (status.div_done)
                begin
                    if (status.req_start)
                    begin
                        cmd.do_start = 1'b1;
                    end
                    else
                    begin
                        cmd.do_eval = 1'b1;
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.out_load = 1'b1;
                if (status.req_start)
                begin
                    cmd.out_kind = KIND_STARTED;
                end
                else if (!status.running)
                begin
                    cmd.out_kind = KIND_NORUN;
                end
                else if (status.rem_zero)
                begin
                    cmd.out_kind = KIND_NOTHING;
                end
                else
                begin
                    cmd.out_kind = KIND_READ;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (!status.rem_zero)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

// File: rtl/core/trace_fifo_drain_tracker_top.sv
// ----------------------------------------------------------------------------
// trace_fifo_drain_tracker_top
// Tracks the write pointer of a circular paragraph trace buffer and issues
// one read command word per complete paragraph that waits.
//
// The input channel (in_valid/in_ready) takes a start or poll word with the
// write pointer and overrun counter. The output channel (out_valid/out_ready)
// returns result words; the final word of each input has last set.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the buffer
// base or the paragraph count, one register per write; the user must use
// it only while idle; the block itself does not enforce this. One input word
// is handled at a time. A start, or a poll while running, shows its first
// result word after one pass of the bit-serial remainder unit (22 steps)
// that reduces the pointer's paragraph modulo the paragraph count; a poll
// that must first reduce a stored next paragraph takes a second pass. A
// poll before any start skips the remainder unit. Read commands follow one
// per cycle while the receiver takes them, then the next input is taken.
// A stalled receiver holds the current output word; nothing is lost.
// Reset clears all tracking state, so a poll before any start answers
// "not running"; the paragraph count resets to 8 and the base to 0.
// ----------------------------------------------------------------------------
module trace_fifo_drain_tracker_top
    import trfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [WORD_W-1:0]    write_pointer,
    input  logic [WORD_W-1:0]    overrun_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    result_kind,
    output logic [IDX_W-1:0]     paragraph_index,
    output logic [WORD_W-1:0]    buffer_offset,
    output logic [WORD_W-1:0]    sequence_res,
    output logic [LOST_W-1:0]    lost_paragraphs,
    output logic                 gap_flag,
    output logic [WORD_W-1:0]    total_overruns,
    output logic [WORD_W-1:0]    total_laps,
    output logic [WORD_W-1:0]    total_lost,
    output logic                 last
);

    trfd_cmd_t    cmd;
    trfd_status_t status;

    trfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    trfd_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .write_pointer   (write_pointer),
        .overrun_count   (overrun_count),
        .cmd             (cmd),
        .status          (status),
        .result_kind     (result_kind),
        .paragraph_index (paragraph_index),
        .buffer_offset   (buffer_offset),
        .sequence_res    (sequence_res),
        .lost_paragraphs (lost_paragraphs),
        .gap_flag        (gap_flag),
        .total_overruns  (total_overruns),
        .total_laps      (total_laps),
        .total_lost      (total_lost),
        .last            (last)
    );

endmodule

// File: rtl/core/trfd_checker.sv
// ----------------------------------------------------------------------------
// trfd_checker
// Port-level checks of the drain tracker, bound to the top level.
// ----------------------------------------------------------------------------
module trfd_checker
    import trfd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [KIND_W-1:0] result_kind,
    input logic [WORD_W-1:0] buffer_offset,
    input logic [WORD_W-1:0] sequence_res,
    input logic [LOST_W-1:0] lost_paragraphs,
    input logic              gap_flag,
    input logic              last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sequence_res)
            && $stable(result_kind) && $stable(last))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while a result is pending");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_READ |-> last)
        else $error("non-read result without last");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gap_flag == (lost_paragraphs != '0))
        else $error("gap flag disagrees with lost count");

    a_norun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_NORUN |->
            buffer_offset == '0 && sequence_res == '0)
        else $error("not-running result carries data");

endmodule

bind trace_fifo_drain_tracker_top trfd_checker u_trfd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .buffer_offset   (buffer_offset),
    .sequence_res    (sequence_res),
    .lost_paragraphs (lost_paragraphs),
    .gap_flag        (gap_flag),
    .last            (last)
);
